@@ hdl/multichannel_tone_burst_generator_unit_macros.svh @@
`ifndef MULTICHANNEL_TONE_BURST_GENERATOR_UNIT_MACROS_SVH
`define MULTICHANNEL_TONE_BURST_GENERATOR_UNIT_MACROS_SVH

// check outside reset
`define MTBG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check on every edge, reset included
`define MTBG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/mtbg_pkg.sv @@
package mtbg_pkg;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_PLAY = 2'd1;
  localparam logic [1:0] OP_STOP = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [1:0]  channel;
    logic [15:0] period;
    logic [15:0] on_time;
    logic [7:0]  burst_count;
  } in_item_t;

  typedef struct packed {
    logic [3:0] pin_levels;
    logic [3:0] playing;
  } out_item_t;

  typedef struct packed {
    in_item_t item;
    logic     last;
  } uop_t;

  typedef struct packed {
    logic [15:0] remaining_ms;
    logic [15:0] high_time;
    logic [15:0] low_time;
    logic [7:0]  cycles_left;
    logic        phase;
  } chan_state_t;

endpackage

@@ hdl/mtbg_issue.sv @@
module mtbg_issue #(
  parameter int CHANNELS = 4,
  parameter int CW       = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  mtbg_pkg::in_item_t in_data,
  input  logic              advance,
  output logic              uop_valid,
  output mtbg_pkg::uop_t    uop,
  output logic [CW-1:0]     uop_ch
);
  import mtbg_pkg::*;

  logic          busy;
  in_item_t      item;
  logic [CW-1:0] idx;
  logic          last;
  logic          take;

  assign last      = (item.operation != OP_TICK) || (idx == CW'(CHANNELS - 1));
  assign take      = busy && advance;
  assign in_stall  = busy && !(advance && last);
  assign uop_valid = busy;
  assign uop       = '{item: item, last: last};
  assign uop_ch    = (item.operation == OP_TICK) ? idx : CW'(item.channel);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else begin
      priority if (in_valid && !in_stall) begin
        busy <= 1'b1;
        item <= in_data;
        idx  <= '0;
      end else if (take && last) begin
        busy <= 1'b0;
      end else if (take) begin
        idx <= idx + CW'(1);
      end
    end
  end

endmodule

@@ hdl/mtbg_chan.sv @@
module mtbg_chan #(
  parameter int CHANNELS = 4,
  parameter int CW       = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic               uop_valid,
  input  mtbg_pkg::uop_t     uop,
  input  logic [CW-1:0]      uop_ch,
  input  logic [3:0]         default_levels,
  output logic               done,
  output mtbg_pkg::out_item_t result
);
  import mtbg_pkg::*;

  localparam int PW = (CHANNELS > 4) ? CHANNELS : 4;

  chan_state_t mem [CHANNELS];
  chan_state_t rd_data;

  logic          s1_valid;
  uop_t          s1_uop;
  logic [CW-1:0] s1_ch;
  logic          s1_fwd;
  chan_state_t   s1_fwd_data;

  logic [CHANNELS-1:0] active;
  logic [CHANNELS-1:0] level;
  logic [CHANNELS-1:0] active_next;
  logic [CHANNELS-1:0] level_next;

  chan_state_t cur;
  chan_state_t wr_data;
  logic        wr_req;
  logic        wr_en;
  logic        in_range;
  logic        idle;
  logic [15:0] rem;
  logic [PW-1:0] dl_pad;
  logic [PW-1:0] act_pad;
  logic [PW-1:0] lvl_pad;

  assign cur      = s1_fwd ? s1_fwd_data : rd_data;
  assign in_range = int'(s1_uop.item.channel) < CHANNELS;
  assign dl_pad   = PW'(default_levels);
  assign idle     = dl_pad[s1_ch];
  assign rem      = cur.remaining_ms - 16'(cur.remaining_ms != 16'd0);
  assign wr_en    = wr_req && advance;
  assign done     = s1_valid && s1_uop.last;

  always_comb begin
    active_next = active;
    level_next  = level;
    wr_req      = 1'b0;
    wr_data     = cur;
    if (s1_valid) begin
      unique case (s1_uop.item.operation)
        OP_TICK: begin
          if (active[s1_ch]) begin
            priority if (rem != 16'd0) begin
              wr_data.remaining_ms = rem;
              wr_req = 1'b1;
            end else if (!cur.phase && cur.cycles_left == 8'd0) begin
              active_next[s1_ch] = 1'b0;
              level_next[s1_ch]  = idle;
            end else begin
              wr_data.cycles_left  = cur.phase ? cur.cycles_left
                                               : cur.cycles_left - 8'd1;
              wr_data.remaining_ms = cur.phase ? cur.low_time : cur.high_time;
              wr_data.phase        = ~cur.phase;
              if (cur.high_time != 16'd0) begin
                level_next[s1_ch] = ~level[s1_ch];
              end
              wr_req = 1'b1;
            end
          end
        end
        OP_PLAY: begin
          if (in_range) begin
            wr_data.remaining_ms = 16'd0;
            wr_data.high_time    = s1_uop.item.on_time;
            wr_data.low_time     = s1_uop.item.period - s1_uop.item.on_time;
            wr_data.cycles_left  = s1_uop.item.burst_count;
            wr_data.phase        = 1'b0;
            wr_req               = 1'b1;
            active_next[s1_ch]   = 1'b1;
          end
        end
        OP_STOP: begin
          if (in_range) begin
            active_next[s1_ch] = 1'b0;
            level_next[s1_ch]  = idle;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign act_pad = PW'(active_next);
  assign lvl_pad = PW'(level_next);
  assign result  = '{pin_levels: lvl_pad[3:0], playing: act_pad[3:0]};

  always_ff @(posedge clk) begin
    if (uop_valid && advance) begin
      rd_data <= mem[uop_ch];
    end
    if (wr_en) begin
      mem[s1_ch] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_uop      <= uop;
      s1_ch       <= uop_ch;
      s1_fwd      <= wr_en && (s1_ch == uop_ch);
      s1_fwd_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      active   <= '0;
      level    <= '0;
    end else if (advance) begin
      s1_valid <= uop_valid;
      active   <= active_next;
      level    <= level_next;
    end
  end

endmodule

@@ hdl/multichannel_tone_burst_generator_unit.sv @@
// channel  | signals                        | accepted when
// ---------+--------------------------------+------------------------------
// input    | in_valid, in_stall, in_data    | in_valid && !in_stall
// output   | out_valid, out_stall, out_data | out_valid && !out_stall
// config   | cfg_wr_en, cfg_wr_data         | cfg_wr_en
//
// A tick sweeps the channel state memory, one channel a cycle unless a stalled result holds the pipeline.
// Play, stop and unused codes issue a single step. Results pass through stage s1, then register in out_data.
// The next item is taken in the cycle its predecessor issues its last channel.
// Synchronous reset idles all channels; the state memory needs no clearing.
// A stalled result holds the pipeline only when the next result is ready.
module multichannel_tone_burst_generator_unit #(
  parameter int CHANNELS = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  mtbg_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mtbg_pkg::out_item_t out_data,
  input  logic                cfg_wr_en,
  input  logic [3:0]          cfg_wr_data
);
  import mtbg_pkg::*;

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic          advance;
  logic          uop_valid;
  uop_t          uop;
  logic [CW-1:0] uop_ch;
  logic          done;
  out_item_t     result;
  logic [3:0]    default_levels;

  assign advance = !(done && out_valid && out_stall);

  mtbg_issue #(.CHANNELS(CHANNELS), .CW(CW)) u_issue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .advance   (advance),
    .uop_valid (uop_valid),
    .uop       (uop),
    .uop_ch    (uop_ch)
  );

  mtbg_chan #(.CHANNELS(CHANNELS), .CW(CW)) u_chan (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .uop_valid      (uop_valid),
    .uop            (uop),
    .uop_ch         (uop_ch),
    .default_levels (default_levels),
    .done           (done),
    .result         (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      default_levels <= '0;
    end else if (cfg_wr_en) begin
      default_levels <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done && advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done && advance) begin
      out_data <= result;
    end
  end

endmodule

@@ hdl/mtbg_checker.sv @@
`include "multichannel_tone_burst_generator_unit_macros.svh"

module mtbg_checker #(
  parameter int CHANNELS = 4
) (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_stall,
  input mtbg_pkg::out_item_t out_data
);
  import mtbg_pkg::*;

  `MTBG_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled item changed")
  `MTBG_ASSERT_ALWAYS(a_rst_idle, rst |=> !out_valid, "item after reset")
  `MTBG_ASSERT(a_play_range, out_valid |-> (out_data.playing >> CHANNELS) == 4'd0, "absent channel playing")
  `MTBG_ASSERT(a_pin_range, out_valid |-> (out_data.pin_levels >> CHANNELS) == 4'd0, "absent channel pin high")

endmodule

bind multichannel_tone_burst_generator_unit mtbg_checker #(.CHANNELS(CHANNELS)) u_checker (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import mtbg_pkg::*;

  localparam int NCH = 4;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum logic [1:0] {ACT_ITEM, ACT_CFG, ACT_DRAIN} act_kind_t;

  typedef struct {
    act_kind_t  kind;
    in_item_t   item;
    logic [3:0] levels;
    int         gap;
  } script_act_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_wr_en = 1'b0;
  logic [3:0] cfg_wr_data = '0;

  script_act_t script_q[$];
  out_item_t   pin_expect[$];

  logic in_took = 1'b0;
  logic out_took = 1'b0;
  int   wait_cnt = 0;
  int   hold_cnt = 0;
  int   result_cnt = 0;
  int   item_no = 0;
  int   errors = 0;

  logic [15:0] ch_remain [NCH] = '{default: '0};
  logic [15:0] ch_high [NCH] = '{default: '0};
  logic [15:0] ch_low [NCH] = '{default: '0};
  logic [7:0]  ch_count [NCH] = '{default: '0};
  logic [NCH-1:0] ch_phase = '0;
  logic [NCH-1:0] ch_active = '0;
  logic [NCH-1:0] ch_level = '0;
  logic [3:0] idle_levels = '0;

  multichannel_tone_burst_generator_unit #(
    .CHANNELS(NCH)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic out_item_t predict_tones(in_item_t it);
    out_item_t r;
    case (it.operation)
      OP_TICK: begin
        for (int c = 0; c < NCH; c++) begin
          if (ch_active[c]) begin
            if (ch_remain[c] != 0) ch_remain[c] = ch_remain[c] - 1'b1;
            if (ch_remain[c] == 0) begin
              if (!ch_phase[c] && ch_count[c] == 0) begin
                ch_active[c] = 1'b0;
                ch_level[c] = idle_levels[c];
              end else begin
                if (!ch_phase[c]) ch_count[c] = ch_count[c] - 1'b1;
                ch_remain[c] = ch_phase[c] ? ch_low[c] : ch_high[c];
                ch_phase[c] = ~ch_phase[c];
                if (ch_high[c] != 0) ch_level[c] = ~ch_level[c];
              end
            end
          end
        end
      end
      OP_PLAY: begin
        ch_high[it.channel] = it.on_time;
        ch_low[it.channel] = it.period - it.on_time;
        ch_phase[it.channel] = 1'b0;
        ch_count[it.channel] = it.burst_count;
        ch_active[it.channel] = 1'b1;
        ch_remain[it.channel] = '0;
      end
      OP_STOP: begin
        ch_active[it.channel] = 1'b0;
        ch_phase[it.channel] = 1'b0;
        ch_level[it.channel] = idle_levels[it.channel];
      end
      default: begin
      end
    endcase
    r.pin_levels = ch_level;
    r.playing = ch_active;
    return r;
  endfunction

  task automatic queue_item(logic [1:0] op, logic [1:0] ch, logic [15:0] per,
                            logic [15:0] ton, logic [7:0] cnt);
    script_act_t a;
    a.kind = ACT_ITEM;
    a.item = '{operation: op, channel: ch, period: per, on_time: ton, burst_count: cnt};
    a.levels = '0;
    case ((item_no / 90) % 3)
      0: a.gap = 0;
      1: a.gap = $urandom_range(0, 18);
      default: a.gap = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 18) : 0;
    endcase
    item_no++;
    script_q.push_back(a);
  endtask

  task automatic queue_barrier(act_kind_t kind, logic [3:0] levels);
    script_act_t a;
    a.kind = kind;
    a.item = '0;
    a.levels = levels;
    a.gap = 12;
    script_q.push_back(a);
  endtask

  // driver: offer queued items, hold each until taken; apply config writes once results drain
  always @(negedge clk) begin
    logic nv;
    logic nw;
    nv = in_valid;
    nw = 1'b0;
    if (in_valid && in_took) nv = 1'b0;
    if (!rst && !nv) begin
      if (wait_cnt > 0) begin
        wait_cnt--;
      end else if (script_q.size() > 0) begin
        if (script_q[0].gap > 0 && (script_q[0].kind == ACT_ITEM || pin_expect.size() == 0)) begin
          wait_cnt = script_q[0].gap - 1;
          script_q[0].gap = 0;
        end else if (script_q[0].kind == ACT_ITEM) begin
          in_data <= script_q[0].item;
          nv = 1'b1;
          void'(script_q.pop_front());
        end else if (pin_expect.size() == 0) begin
          if (script_q[0].kind == ACT_CFG) begin
            nw = 1'b1;
            cfg_wr_data <= script_q[0].levels;
          end
          void'(script_q.pop_front());
        end
      end
    end
    in_valid <= nv;
    cfg_wr_en <= nw;
  end

  // receiver: draw a hold per result, with two long hold-offs
  always @(negedge clk) begin
    if (!rst) begin
      if (out_took) begin
        if (result_cnt == 300 || result_cnt == 1100) begin
          hold_cnt = 400;
        end else begin
          case ((result_cnt / 128) % 3)
            0: hold_cnt = 0;
            1: hold_cnt = $urandom_range(0, 18);
            default: hold_cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
          endcase
        end
      end
      out_stall <= (hold_cnt > 0);
      if (hold_cnt > 0) hold_cnt--;
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      in_took <= 1'b0;
      out_took <= 1'b0;
    end else begin
      in_took <= in_valid && !in_stall;
      out_took <= out_valid && !out_stall;
      if (cfg_wr_en) idle_levels = cfg_wr_data;
      if (out_valid && !out_stall) begin
        result_cnt <= result_cnt + 1;
        if (pin_expect.size() == 0) begin
          $error("unexpected item: pin_levels %h playing %h",
                 out_data.pin_levels, out_data.playing);
          errors++;
        end else begin
          want = pin_expect.pop_front();
          if (out_data.pin_levels !== want.pin_levels) begin
            $error("pin_levels: expected %h, got %h", want.pin_levels, out_data.pin_levels);
            errors++;
          end
          if (out_data.playing !== want.playing) begin
            $error("playing: expected %h, got %h", want.playing, out_data.playing);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) pin_expect.push_back(predict_tones(in_data));
    end
  end

  initial begin
    #(10_000_000);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [1:0]  op;
    logic [1:0]  ch;
    logic [15:0] per;
    logic [15:0] ton;
    logic [7:0]  cnt;
    logic [3:0]  phase_levels [4];
    int r;

    queue_barrier(ACT_CFG, 4'b0101);
    for (int c = 0; c < NCH; c++) queue_item(OP_STOP, 2'(c), '0, '0, '0);
    queue_item(OP_PLAY, 2'd0, 16'd3, 16'd1, 8'd1);
    queue_item(OP_PLAY, 2'd1, 16'd0, 16'd0, 8'd0);
    queue_item(OP_PLAY, 2'd2, 16'hFFFF, 16'hFFFF, 8'hFF);
    queue_item(OP_PLAY, 2'd3, 16'd2, 16'd5, 8'd0);
    for (int k = 0; k < 6; k++) queue_item(OP_TICK, 2'(k), '1, '0, '1);
    queue_item(OP_UNUSED, 2'd3, 16'hFFFF, 16'hFFFF, 8'hFF);
    queue_item(OP_PLAY, 2'd0, 16'd4, 16'd2, 8'd2);
    for (int k = 0; k < 4; k++) queue_item(OP_TICK, '0, '0, '1, '0);
    queue_item(OP_STOP, 2'd2, '0, '0, '0);
    queue_item(OP_STOP, 2'd3, '0, '0, '0);

    phase_levels[0] = 4'hF;
    phase_levels[1] = 4'h0;
    phase_levels[2] = 4'($urandom);
    phase_levels[3] = 4'b1001;
    for (int p = 0; p < 4; p++) begin
      queue_barrier(ACT_CFG, phase_levels[p]);
      for (int n = 0; n < 475; n++) begin
        if (p == 2 && n == 300) queue_barrier(ACT_DRAIN, '0);
        r = $urandom_range(0, 99);
        ch = 2'($urandom);
        per = 16'($urandom);
        ton = 16'($urandom);
        cnt = 8'($urandom);
        if (r < 58) begin
          op = OP_TICK;
        end else if (r < 83) begin
          op = OP_PLAY;
          if ($urandom_range(0, 9) != 0) begin
            per = 16'($urandom_range(1, 9));
            ton = 16'($urandom_range(0, per));
            cnt = 8'($urandom_range(0, 4));
          end else if ($urandom_range(0, 1) == 0) begin
            per = 16'($urandom_range(0, 3));
            ton = per + 16'($urandom_range(1, 3));
          end
        end else if (r < 95) begin
          op = OP_STOP;
        end else begin
          op = OP_UNUSED;
        end
        queue_item(op, ch, per, ton, cnt);
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (script_q.size() == 0);
    @(posedge clk);
    while (in_valid || pin_expect.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
